// ----- src/assert_macros.svh -----
// Assertion macros for the RTL of the hangar door supervisor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge, skipped while reset is held low.
`define HDS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define HDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HDS_ASSERT(lbl, clk, rst_n, prop, msg)
`define HDS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- src/hds_pkg.sv -----
// Types, codes and reset values for the hangar door supervisor.
package hds_pkg;

    // Operating modes, encoded as reported on the mode output
    typedef enum logic [2:0] {
        M_INSIDE  = 3'd0,
        M_TAKEOFF = 3'd1,
        M_OUT     = 3'd2,
        M_LANDING = 3'd3,
        M_PRE     = 3'd4,
        M_ALARM   = 3'd5
    } t_mode;

    // Screen message codes
    typedef enum logic [2:0] {
        SC_INSIDE  = 3'd0,
        SC_TAKEOFF = 3'd1,
        SC_OUT     = 3'd2,
        SC_LANDING = 3'd3,
        SC_ALARM   = 3'd4
    } t_screen;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TAKEOFF_DIST  = 3'd0,
        CFG_LANDING_DIST  = 3'd1,
        CFG_TEMP_THR      = 3'd2,
        CFG_TAKEOFF_HOLD  = 3'd3,
        CFG_LANDING_HOLD  = 3'd4,
        CFG_PREALARM_DLY  = 3'd5,
        CFG_ALARM_DLY     = 3'd6
    } t_cfg_idx;

    localparam int TIMER_BITS_DEF = 16;

    localparam int DIST_W  = 10;
    localparam int TEMP_W  = 12;
    localparam int TICKS_W = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    // Register reset values
    localparam logic [DIST_W-1:0]         RST_TAKEOFF_DIST = 10'd100;
    localparam logic [DIST_W-1:0]         RST_LANDING_DIST = 10'd10;
    localparam logic signed [TEMP_W-1:0]  RST_TEMP_THR     = 12'sd400;
    localparam logic [TICKS_W-1:0]        RST_TAKEOFF_HOLD = 16'd50;
    localparam logic [TICKS_W-1:0]        RST_LANDING_HOLD = 16'd50;
    localparam logic [TICKS_W-1:0]        RST_PREALARM_DLY = 16'd50;
    localparam logic [TICKS_W-1:0]        RST_ALARM_DLY    = 16'd100;

endpackage

// ----- src/hangar_door_supervisor_fsm.sv -----
// Hangar door supervisor: mode machine, qualifying and heat timers, latched outputs.
//
// One input item is one sensor tick and produces exactly one result item with the
// mode, the latched door/lamp/screen states and an alarm-entry pulse. An item is
// captured in an input register, evaluated against the mode, timer and request
// state in combinational logic, and written to a result register; the block takes
// one item per clock cycle while the result side is not stalled. Back-pressure on
// the result side stalls both stages; the input register keeps accepting while
// the result register can drain in the same cycle. Timers count ticks and
// saturate at 2^TIMER_BITS-1. Configuration registers are written through the
// plain write port and take effect on the next item.
module hangar_door_supervisor_fsm #(
    parameter int TIMER_BITS = hds_pkg::TIMER_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port
    input  logic                        i_cfg_we,
    input  logic [hds_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [hds_pkg::CFG_W-1:0]   i_cfg_data,
    // Input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [hds_pkg::DIST_W-1:0]  i_distance_cm,
    input  logic signed [hds_pkg::TEMP_W-1:0] i_temperature,
    input  logic                        i_motion_seen,
    input  logic                        i_takeoff_request,
    input  logic                        i_land_request,
    input  logic                        i_reset_pressed,
    // Result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [2:0]                  o_mode_now,
    output logic                        o_door_open,
    output logic                        o_lamp_inside,
    output logic                        o_lamp_moving_blink,
    output logic                        o_lamp_alarm,
    output logic [2:0]                  o_screen_code,
    output logic                        o_alarm_entered
);
    import hds_pkg::*;

    `include "assert_macros.svh"

    localparam int CMP_W = (TIMER_BITS > TICKS_W) ? TIMER_BITS : TICKS_W;

    // Configuration registers
    logic [DIST_W-1:0]        r_takeoff_dist;
    logic [DIST_W-1:0]        r_landing_dist;
    logic signed [TEMP_W-1:0] r_temp_thr;
    logic [TICKS_W-1:0]       r_takeoff_hold;
    logic [TICKS_W-1:0]       r_landing_hold;
    logic [TICKS_W-1:0]       r_prealarm_dly;
    logic [TICKS_W-1:0]       r_alarm_dly;

    // Input stage
    logic                     r_in_valid;
    logic [DIST_W-1:0]        r_in_dist;
    logic signed [TEMP_W-1:0] r_in_temp;
    logic                     r_in_motion;
    logic                     r_in_tk_req;
    logic                     r_in_ld_req;
    logic                     r_in_pressed;

    // Supervisor state
    t_mode                    r_mode, n_mode;
    t_mode                    r_ret_mode, n_ret_mode;
    logic                     r_mt_act, n_mt_act;
    logic [TIMER_BITS-1:0]    r_mt_cnt, n_mt_cnt;
    logic                     r_ht_act, n_ht_act;
    logic [TIMER_BITS-1:0]    r_ht_cnt, n_ht_cnt;
    logic                     r_tk_pend, n_tk_pend;
    logic                     r_ld_pend, n_ld_pend;
    logic                     r_door, n_door;
    logic                     r_lamp_in, n_lamp_in;
    logic                     r_blink, n_blink;
    logic                     r_lamp_alarm, n_lamp_alarm;
    t_screen                  r_screen, n_screen;
    logic                     n_alarm_entered;

    // Result stage
    logic                     r_out_valid;
    t_mode                    r_out_mode;
    logic                     r_out_door;
    logic                     r_out_lamp_in;
    logic                     r_out_blink;
    logic                     r_out_lamp_alarm;
    t_screen                  r_out_screen;
    logic                     r_out_alarm_entered;

    logic                     out_free;
    logic                     in_move;

    // Handshake: result register can take a new item when empty or draining
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_move    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_takeoff_dist <= RST_TAKEOFF_DIST;
            r_landing_dist <= RST_LANDING_DIST;
            r_temp_thr     <= RST_TEMP_THR;
            r_takeoff_hold <= RST_TAKEOFF_HOLD;
            r_landing_hold <= RST_LANDING_HOLD;
            r_prealarm_dly <= RST_PREALARM_DLY;
            r_alarm_dly    <= RST_ALARM_DLY;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TAKEOFF_DIST: r_takeoff_dist <= i_cfg_data[DIST_W-1:0];
                CFG_LANDING_DIST: r_landing_dist <= i_cfg_data[DIST_W-1:0];
                CFG_TEMP_THR:     r_temp_thr     <= $signed(i_cfg_data[TEMP_W-1:0]);
                CFG_TAKEOFF_HOLD: r_takeoff_hold <= i_cfg_data[TICKS_W-1:0];
                CFG_LANDING_HOLD: r_landing_hold <= i_cfg_data[TICKS_W-1:0];
                CFG_PREALARM_DLY: r_prealarm_dly <= i_cfg_data[TICKS_W-1:0];
                CFG_ALARM_DLY:    r_alarm_dly    <= i_cfg_data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the input item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_dist    <= i_distance_cm;
            r_in_temp    <= i_temperature;
            r_in_motion  <= i_motion_seen;
            r_in_tk_req  <= i_takeoff_request;
            r_in_ld_req  <= i_land_request;
            r_in_pressed <= i_reset_pressed;
        end
    end

    // Tick-level conditions
    logic                  far_ok, near_ok, hot;
    logic [TIMER_BITS-1:0] mt_inc, ht_inc;
    logic                  q_near_sel, q_ok, q_exp;
    logic [TICKS_W-1:0]    q_hold;
    logic [TIMER_BITS-1:0] q_cnt;
    logic                  heat_exp, alarm_exp;

    assign far_ok  = r_in_dist >= r_takeoff_dist;
    assign near_ok = r_in_dist <= r_landing_dist;
    assign hot     = r_in_temp >= r_temp_thr;

    // Advance active timers, saturating at all ones
    assign mt_inc = (r_mt_act && !(&r_mt_cnt)) ? r_mt_cnt + 1'b1 : r_mt_cnt;
    assign ht_inc = (r_ht_act && !(&r_ht_cnt)) ? r_ht_cnt + 1'b1 : r_ht_cnt;

    // Qualifying timer: landing limit while landing, take-off limit otherwise
    assign q_near_sel = (r_mode == M_LANDING) ||
                        ((r_mode == M_PRE) && (r_ret_mode == M_LANDING));
    assign q_ok   = q_near_sel ? near_ok : far_ok;
    assign q_hold = q_near_sel ? r_landing_hold : r_takeoff_hold;
    assign q_exp  = q_ok && r_mt_act && (CMP_W'(mt_inc) >= CMP_W'(q_hold));
    assign q_cnt  = (q_ok && r_mt_act) ? mt_inc : '0;

    assign heat_exp  = hot && r_ht_act && (CMP_W'(ht_inc) >= CMP_W'(r_prealarm_dly));
    assign alarm_exp = r_ht_act && (CMP_W'(ht_inc) >= CMP_W'(r_alarm_dly));

    // Next state for one tick
    always_comb begin
        logic do_heat;
        do_heat         = 1'b0;
        n_mode          = r_mode;
        n_ret_mode      = r_ret_mode;
        n_mt_act        = r_mt_act;
        n_mt_cnt        = mt_inc;
        n_ht_act        = r_ht_act;
        n_ht_cnt        = ht_inc;
        n_tk_pend       = r_tk_pend || r_in_tk_req;
        n_ld_pend       = r_ld_pend || r_in_ld_req;
        n_door          = r_door;
        n_lamp_in       = r_lamp_in;
        n_blink         = r_blink;
        n_lamp_alarm    = r_lamp_alarm;
        n_screen        = r_screen;
        n_alarm_entered = 1'b0;

        case (r_mode)
            M_INSIDE: begin
                if (n_tk_pend) begin
                    n_tk_pend = 1'b0;
                    n_lamp_in = 1'b0;
                    n_door    = 1'b1;
                    n_screen  = SC_TAKEOFF;
                    n_mt_act  = 1'b0;
                    n_mt_cnt  = '0;
                    n_mode    = M_TAKEOFF;
                end
                do_heat = 1'b1;
            end
            M_TAKEOFF: begin
                n_blink  = 1'b1;
                n_mt_act = q_ok;
                n_mt_cnt = q_cnt;
                if (q_exp) begin
                    n_door    = 1'b0;
                    n_screen  = SC_OUT;
                    n_blink   = 1'b0;
                    n_ld_pend = 1'b0;
                    n_mode    = M_OUT;
                end
                do_heat = 1'b1;
            end
            M_OUT: begin
                if (n_ld_pend && r_in_motion) begin
                    n_ld_pend = 1'b0;
                    n_door    = 1'b1;
                    n_screen  = SC_LANDING;
                    n_mt_act  = 1'b0;
                    n_mt_cnt  = '0;
                    n_mode    = M_LANDING;
                end
            end
            M_LANDING: begin
                n_blink  = 1'b1;
                n_mt_act = q_ok;
                n_mt_cnt = q_cnt;
                if (q_exp) begin
                    n_door    = 1'b0;
                    n_screen  = SC_INSIDE;
                    n_lamp_in = 1'b1;
                    n_blink   = 1'b0;
                    n_tk_pend = 1'b0;
                    n_mode    = M_INSIDE;
                end
                do_heat = 1'b1;
            end
            M_PRE: begin
                // Keep qualifying a move that was under way
                if (r_ret_mode == M_LANDING || r_ret_mode == M_TAKEOFF) begin
                    n_blink  = 1'b1;
                    n_mt_act = q_ok;
                    n_mt_cnt = q_cnt;
                    if (q_exp) begin
                        n_door  = 1'b0;
                        n_blink = 1'b0;
                        if (r_ret_mode == M_LANDING) begin
                            n_ret_mode = M_INSIDE;
                            n_lamp_in  = 1'b1;
                        end else begin
                            n_ret_mode = M_OUT;
                        end
                    end
                end
                priority if (!hot) begin
                    n_mode = n_ret_mode;
                end else if (alarm_exp) begin
                    if (n_ret_mode == M_LANDING) begin
                        n_ret_mode = M_INSIDE;
                    end else if (n_ret_mode == M_TAKEOFF) begin
                        n_ret_mode = M_OUT;
                    end
                    n_door          = 1'b0;
                    n_lamp_alarm    = 1'b1;
                    n_lamp_in       = 1'b0;
                    n_blink         = 1'b0;
                    n_screen        = SC_ALARM;
                    n_mode          = M_ALARM;
                    n_alarm_entered = 1'b1;
                end else begin
                    // Hold pre-alarm while the alarm delay runs
                end
            end
            M_ALARM: begin
                if (r_in_pressed) begin
                    n_lamp_alarm = 1'b0;
                    n_ht_act     = 1'b0;
                    n_ht_cnt     = '0;
                    if (r_ret_mode == M_INSIDE) begin
                        n_lamp_in = 1'b1;
                        n_screen  = SC_INSIDE;
                    end else begin
                        n_screen  = SC_OUT;
                    end
                    n_mode = r_ret_mode;
                end
            end
            default: ;
        endcase

        // Heat check sees the mode reached in this tick
        if (do_heat) begin
            n_ht_act = hot;
            n_ht_cnt = (hot && r_ht_act) ? ht_inc : '0;
            if (heat_exp) begin
                if (n_mode == M_INSIDE) begin
                    n_door = 1'b0;
                end
                n_ret_mode = n_mode;
                n_ht_cnt   = '0;
                n_mode     = M_PRE;
            end
        end
    end

    // Update supervisor state once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_INSIDE;
            r_ret_mode   <= M_INSIDE;
            r_mt_act     <= 1'b0;
            r_mt_cnt     <= '0;
            r_ht_act     <= 1'b0;
            r_ht_cnt     <= '0;
            r_tk_pend    <= 1'b0;
            r_ld_pend    <= 1'b0;
            r_door       <= 1'b0;
            r_lamp_in    <= 1'b1;
            r_blink      <= 1'b0;
            r_lamp_alarm <= 1'b0;
            r_screen     <= SC_INSIDE;
        end else if (in_move) begin
            r_mode       <= n_mode;
            r_ret_mode   <= n_ret_mode;
            r_mt_act     <= n_mt_act;
            r_mt_cnt     <= n_mt_cnt;
            r_ht_act     <= n_ht_act;
            r_ht_cnt     <= n_ht_cnt;
            r_tk_pend    <= n_tk_pend;
            r_ld_pend    <= n_ld_pend;
            r_door       <= n_door;
            r_lamp_in    <= n_lamp_in;
            r_blink      <= n_blink;
            r_lamp_alarm <= n_lamp_alarm;
            r_screen     <= n_screen;
        end
    end

    // Hold the result item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_move) begin
            r_out_mode          <= n_mode;
            r_out_door          <= n_door;
            r_out_lamp_in       <= n_lamp_in;
            r_out_blink         <= n_blink;
            r_out_lamp_alarm    <= n_lamp_alarm;
            r_out_screen        <= n_screen;
            r_out_alarm_entered <= n_alarm_entered;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_mode_now          = r_out_mode;
    assign o_door_open         = r_out_door;
    assign o_lamp_inside       = r_out_lamp_in;
    assign o_lamp_moving_blink = r_out_blink;
    assign o_lamp_alarm        = r_out_lamp_alarm;
    assign o_screen_code       = r_out_screen;
    assign o_alarm_entered     = r_out_alarm_entered;

    // Checks on the supervisor logic
    `HDS_ASSERT(a_alarm_pulse_mode, i_clk, i_rst_n, (o_out_valid && o_alarm_entered) |-> (o_mode_now == M_ALARM && o_lamp_alarm), "alarm pulse without alarm mode and lamp")
    `HDS_ASSERT(a_alarm_lamp, i_clk, i_rst_n, (r_mode == M_ALARM) |-> r_lamp_alarm, "alarm mode with alarm lamp off")
    `HDS_ASSERT(a_timer_idle_zero, i_clk, i_rst_n, (r_mt_act || r_mt_cnt == '0) && (r_ht_act || r_ht_cnt == '0), "inactive timer holds a count")
    `HDS_ASSERT(a_door_open_mode, i_clk, i_rst_n, r_door |-> (r_mode == M_TAKEOFF || r_mode == M_LANDING || r_mode == M_PRE), "door open in a resting mode")
    `HDS_ASSERT(a_state_holds, i_clk, i_rst_n, !in_move |=> $stable(r_mode) && $stable(r_ret_mode), "mode changed without an item")

endmodule
